[rtl/triangle_normal_and_area_assert.svh]
// assertion macros used by the top rtl file
`ifndef TRIANGLE_NORMAL_AND_AREA_ASSERT_SVH
`define TRIANGLE_NORMAL_AND_AREA_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, held off during reset
`define TNA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, also checked across reset
`define TNA_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define TNA_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TNA_ASSERT_NEXT(lbl, clk, ante, cons)

`endif

`endif

[rtl/tna_pkg.sv]
package tna_pkg;

   // pipeline control shared by every stage module
   typedef struct packed {
      logic advance;
      logic clear;
   } pipe_ctl_type;

   // width of the degenerate limit register
   localparam int CSR_WIDTH = 16;

endpackage

[rtl/tna_req_if.sv]
interface tna_req_if #(
   parameter int COORD_BITS = 24
);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] a_x;
   logic signed [COORD_BITS-1:0] a_y;
   logic signed [COORD_BITS-1:0] a_z;
   logic signed [COORD_BITS-1:0] b_x;
   logic signed [COORD_BITS-1:0] b_y;
   logic signed [COORD_BITS-1:0] b_z;
   logic signed [COORD_BITS-1:0] c_x;
   logic signed [COORD_BITS-1:0] c_y;
   logic signed [COORD_BITS-1:0] c_z;

   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   input ready);
   modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                 output ready);
endinterface

[rtl/tna_rsp_if.sv]
interface tna_rsp_if #(
   parameter int AREA_BITS   = 38,
   parameter int NORMAL_BITS = 16
);
   logic valid;
   logic ready;
   logic [AREA_BITS-1:0] area;
   logic signed [NORMAL_BITS-1:0] normal_x;
   logic signed [NORMAL_BITS-1:0] normal_y;
   logic signed [NORMAL_BITS-1:0] normal_z;
   logic degenerate;

   modport source (output valid, area, normal_x, normal_y, normal_z, degenerate,
                   input ready);
   modport sink (input valid, area, normal_x, normal_y, normal_z, degenerate,
                 output ready);
endinterface

[rtl/tna_cross.sv]
module tna_cross import tna_pkg::*; #(
   parameter int COORD_BITS = 24
) (
   input  logic clock,
   input  pipe_ctl_type ctl,
   input  logic in_valid,
   input  logic signed [COORD_BITS-1:0] pa [3],
   input  logic signed [COORD_BITS-1:0] pb [3],
   input  logic signed [COORD_BITS-1:0] pc [3],
   output logic out_valid,
   output logic signed [2*COORD_BITS+2:0] v [3]
);
   localparam int EB = COORD_BITS + 1;
   localparam int PB = 2 * EB;
   localparam int VB = PB + 1;

   logic [2:0] vld_ff;
   logic signed [EB-1:0] e1_ff [3];
   logic signed [EB-1:0] e2_ff [3];
   logic signed [PB-1:0] p_ff [6];
   logic signed [VB-1:0] v_ff [3];

   // valid bits move with the data
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         vld_ff <= '0;
      end else if (ctl.advance) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   // edges, then cross terms, then their differences
   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= EB'(pb[i]) - EB'(pa[i]);
            e2_ff[i] <= EB'(pc[i]) - EB'(pa[i]);
         end
         p_ff[0] <= PB'(e1_ff[1]) * PB'(e2_ff[2]);
         p_ff[1] <= PB'(e1_ff[2]) * PB'(e2_ff[1]);
         p_ff[2] <= PB'(e1_ff[2]) * PB'(e2_ff[0]);
         p_ff[3] <= PB'(e1_ff[0]) * PB'(e2_ff[2]);
         p_ff[4] <= PB'(e1_ff[0]) * PB'(e2_ff[1]);
         p_ff[5] <= PB'(e1_ff[1]) * PB'(e2_ff[0]);
         for (int i = 0; i < 3; i++) begin
            v_ff[i] <= VB'(p_ff[2*i]) - VB'(p_ff[2*i+1]);
         end
      end
   end

   assign out_valid = vld_ff[2];
   assign v = v_ff;
endmodule

[rtl/tna_square.sv]
module tna_square import tna_pkg::*; #(
   parameter int VB = 51
) (
   input  logic clock,
   input  pipe_ctl_type ctl,
   input  logic in_valid,
   input  logic signed [VB-1:0] v [3],
   output logic out_valid,
   output logic [2*VB-1:0] s,
   output logic [VB-2:0] mag [3],
   output logic [2:0] neg
);
   localparam int MB = VB - 1;
   localparam int LO = (MB + 1) / 2;
   localparam int HI = MB - LO;
   localparam int SW = 2 * MB;
   localparam int TW = 2 * MB + 2;

   logic [3:0] vld_ff;
   logic [MB-1:0] mag_ff [4][3];
   logic [2:0] neg_ff [4];
   logic [2*HI-1:0] hh_ff [3];
   logic [HI+LO-1:0] hl_ff [3];
   logic [2*LO-1:0] ll_ff [3];
   logic [SW-1:0] sq_ff [3];
   logic [TW-1:0] s_ff;
   logic [VB-1:0] abs_in [3];

   // magnitude of each cross component
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_in[i] = v[i][VB-1] ? VB'(-v[i]) : VB'(v[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         vld_ff <= '0;
      end else if (ctl.advance) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   // split squares into half-width partial products, then recombine and sum
   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[0][i] <= abs_in[i][MB-1:0];
            neg_ff[0][i] <= v[i][VB-1];
            hh_ff[i] <= (2*HI)'(mag_ff[0][i][MB-1:LO]) * (2*HI)'(mag_ff[0][i][MB-1:LO]);
            hl_ff[i] <= (HI+LO)'(mag_ff[0][i][MB-1:LO]) * (HI+LO)'(mag_ff[0][i][LO-1:0]);
            ll_ff[i] <= (2*LO)'(mag_ff[0][i][LO-1:0]) * (2*LO)'(mag_ff[0][i][LO-1:0]);
            sq_ff[i] <= (SW'(hh_ff[i]) << (2*LO)) + (SW'(hl_ff[i]) << (LO+1))
                      + SW'(ll_ff[i]);
         end
         for (int k = 1; k < 4; k++) begin
            mag_ff[k] <= mag_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
         s_ff <= TW'(sq_ff[0]) + TW'(sq_ff[1]) + TW'(sq_ff[2]);
      end
   end

   assign out_valid = vld_ff[3];
   assign s = s_ff;
   assign mag = mag_ff[3];
   assign neg = neg_ff[3];
endmodule

[rtl/tna_sqrt.sv]
module tna_sqrt import tna_pkg::*; #(
   parameter int RB        = 51,
   parameter int SIDE_BITS = 153
) (
   input  logic clock,
   input  pipe_ctl_type ctl,
   input  logic in_valid,
   input  logic [2*RB-1:0] s,
   input  logic [SIDE_BITS-1:0] side_in,
   output logic out_valid,
   output logic [RB-1:0] root,
   output logic [SIDE_BITS-1:0] side_out
);
   logic [RB-1:0] vld_ff;
   logic [RB+1:0] rem_ff [RB];
   logic [RB-1:0] root_ff [RB];
   logic [2*RB-1:0] sl_ff [RB];
   logic [SIDE_BITS-1:0] side_ff [RB];

   logic [RB+1:0] rem_prev [RB];
   logic [RB-1:0] root_prev [RB];
   logic [2*RB-1:0] sl_prev [RB];
   logic [RB+1:0] cur [RB];
   logic [RB+1:0] trial [RB];

   // each stage settles one root bit from the next two radicand bits
   always_comb begin
      rem_prev[0] = '0;
      root_prev[0] = '0;
      sl_prev[0] = s;
      for (int k = 1; k < RB; k++) begin
         rem_prev[k] = rem_ff[k-1];
         root_prev[k] = root_ff[k-1];
         sl_prev[k] = sl_ff[k-1];
      end
      for (int k = 0; k < RB; k++) begin
         cur[k] = {rem_prev[k][RB-1:0], sl_prev[k][2*RB-1 -: 2]};
         trial[k] = {root_prev[k], 2'b01};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         vld_ff <= '0;
      end else if (ctl.advance) begin
         vld_ff <= {vld_ff[RB-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         for (int k = 0; k < RB; k++) begin
            if (cur[k] >= trial[k]) begin
               rem_ff[k] <= cur[k] - trial[k];
               root_ff[k] <= {root_prev[k][RB-2:0], 1'b1};
            end else begin
               rem_ff[k] <= cur[k];
               root_ff[k] <= {root_prev[k][RB-2:0], 1'b0};
            end
            sl_ff[k] <= {sl_prev[k][2*RB-3:0], 2'b00};
         end
         side_ff[0] <= side_in;
         for (int k = 1; k < RB; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[RB-1];
   assign root = root_ff[RB-1];
   assign side_out = side_ff[RB-1];
endmodule

[rtl/tna_div.sv]
module tna_div import tna_pkg::*; #(
   parameter int MB = 50,
   parameter int NF = 14,
   parameter int CF = 12
) (
   input  logic clock,
   input  pipe_ctl_type ctl,
   input  logic in_valid,
   input  logic [CSR_WIDTH-1:0] limit,
   input  logic [MB:0] root,
   input  logic [MB-1:0] mag [3],
   input  logic [2:0] neg,
   output logic out_valid,
   output logic [MB-CF-1:0] area,
   output logic signed [NF+1:0] nrm [3],
   output logic degen
);
   localparam int RB = MB + 1;
   localparam int NS = NF + 1;
   localparam int NB = NF + 2;
   localparam int AB = RB - CF - 1;
   localparam int LW = RB - CF + CSR_WIDTH;

   logic [NS:0] vld_ff;
   logic [RB:0] r_ff [NS][3];
   logic [NF:0] q_ff [NS][3];
   logic [RB-1:0] root_ff [NS];
   logic [2:0] neg_ff [NS];
   logic [AB-1:0] area_ff [NS];
   logic [NS-1:0] degen_ff;
   logic signed [NB-1:0] nrm_ff [3];
   logic [AB-1:0] area_out_ff;
   logic degen_out_ff;

   logic [RB:0] r_first [3];
   logic [RB:0] r_dbl [NS][3];
   logic degen_in;

   // first quotient bit, length check against the limit
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r_first[i] = (RB+1)'(mag[i]);
      end
      for (int k = 0; k < NS; k++) begin
         for (int i = 0; i < 3; i++) begin
            r_dbl[k][i] = {r_ff[k][i][RB-1:0], 1'b0};
         end
      end
      degen_in = LW'(root >> CF) <= LW'(limit);
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         vld_ff <= '0;
      end else if (ctl.advance) begin
         vld_ff <= {vld_ff[NS-1:0], in_valid};
      end
   end

   // restoring division, one quotient bit per stage for each lane
   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         for (int i = 0; i < 3; i++) begin
            if (r_first[i] >= (RB+1)'(root)) begin
               r_ff[0][i] <= r_first[i] - (RB+1)'(root);
               q_ff[0][i] <= (NF+1)'(1);
            end else begin
               r_ff[0][i] <= r_first[i];
               q_ff[0][i] <= '0;
            end
         end
         root_ff[0] <= root;
         neg_ff[0] <= neg;
         area_ff[0] <= AB'(root >> (CF + 1));
         degen_ff[0] <= degen_in;
         for (int k = 1; k < NS; k++) begin
            for (int i = 0; i < 3; i++) begin
               if (r_dbl[k-1][i] >= (RB+1)'(root_ff[k-1])) begin
                  r_ff[k][i] <= r_dbl[k-1][i] - (RB+1)'(root_ff[k-1]);
                  q_ff[k][i] <= {q_ff[k-1][i][NF-1:0], 1'b1};
               end else begin
                  r_ff[k][i] <= r_dbl[k-1][i];
                  q_ff[k][i] <= {q_ff[k-1][i][NF-1:0], 1'b0};
               end
            end
            root_ff[k] <= root_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            area_ff[k] <= area_ff[k-1];
            degen_ff[k] <= degen_ff[k-1];
         end
         // sign and degenerate masking into the output register
         for (int i = 0; i < 3; i++) begin
            if (degen_ff[NS-1]) begin
               nrm_ff[i] <= '0;
            end else if (neg_ff[NS-1][i]) begin
               nrm_ff[i] <= -$signed(NB'(q_ff[NS-1][i]));
            end else begin
               nrm_ff[i] <= $signed(NB'(q_ff[NS-1][i]));
            end
         end
         area_out_ff <= area_ff[NS-1];
         degen_out_ff <= degen_ff[NS-1];
      end
   end

   assign out_valid = vld_ff[NS];
   assign area = area_out_ff;
   assign nrm = nrm_ff;
   assign degen = degen_out_ff;
endmodule

[rtl/triangle_normal_and_area.sv]
// Triangle face normal and area. Takes three vertices in signed fixed point
// (COORD_FRAC_BITS fraction bits), forms the cross product of edges ab and ac
// from vertex a, and returns half its length (rounded down) as the area and
// the unit normal with NORMAL_FRAC_BITS fraction bits, truncated toward zero.
// When the length (in coordinate units) is at or below the degenerate limit
// register, the normal is zero and degenerate is set; the area is still
// given. One item is accepted every cycle unless the sink holds a result.
// The pipeline forms the edges and cross product, then the sum of squares,
// then the square root, then the quotient bits in the normal divider lanes,
// and last the output register. When the result is held by the sink the
// whole pipeline holds. The user must write the limit register only while no
// item is in flight; the block itself does not enforce it.
`include "triangle_normal_and_area_assert.svh"

module triangle_normal_and_area import tna_pkg::*; #(
   parameter int COORD_BITS       = 24,
   parameter int COORD_FRAC_BITS  = 12,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic clock,
   input  logic reset,
   tna_req_if.sink req_chan,
   tna_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [CSR_WIDTH-1:0] csr_wdata
);
   localparam int VB = 2 * COORD_BITS + 3;
   localparam int MB = VB - 1;
   localparam int RB = MB + 1;
   localparam int NB = NORMAL_FRAC_BITS + 2;
   localparam int ONE = 2 ** NORMAL_FRAC_BITS;

   pipe_ctl_type ctl;
   logic [CSR_WIDTH-1:0] limit_ff;

   logic signed [COORD_BITS-1:0] pa [3];
   logic signed [COORD_BITS-1:0] pb [3];
   logic signed [COORD_BITS-1:0] pc [3];
   logic cross_valid;
   logic signed [VB-1:0] v [3];
   logic sq_valid;
   logic [2*RB-1:0] s;
   logic [MB-1:0] mag [3];
   logic [2:0] neg;
   logic [3*MB+2:0] side_in;
   logic [3*MB+2:0] side_out;
   logic root_valid;
   logic [RB-1:0] root;
   logic [MB-1:0] mag_d [3];
   logic signed [NB-1:0] nrm [3];

   // degenerate limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // whole pipeline moves unless a finished item waits at the output
   assign ctl.advance = !rsp_chan.valid || rsp_chan.ready;
   assign ctl.clear = reset;
   assign req_chan.ready = ctl.advance;

   assign pa[0] = req_chan.a_x;
   assign pa[1] = req_chan.a_y;
   assign pa[2] = req_chan.a_z;
   assign pb[0] = req_chan.b_x;
   assign pb[1] = req_chan.b_y;
   assign pb[2] = req_chan.b_z;
   assign pc[0] = req_chan.c_x;
   assign pc[1] = req_chan.c_y;
   assign pc[2] = req_chan.c_z;

   tna_cross #(.COORD_BITS(COORD_BITS)) u_cross (
      .clock(clock), .ctl(ctl), .in_valid(req_chan.valid),
      .pa(pa), .pb(pb), .pc(pc), .out_valid(cross_valid), .v(v)
   );

   tna_square #(.VB(VB)) u_square (
      .clock(clock), .ctl(ctl), .in_valid(cross_valid), .v(v),
      .out_valid(sq_valid), .s(s), .mag(mag), .neg(neg)
   );

   // magnitudes and signs ride alongside the root
   assign side_in = {neg, mag[2], mag[1], mag[0]};

   tna_sqrt #(.RB(RB), .SIDE_BITS(3*MB+3)) u_sqrt (
      .clock(clock), .ctl(ctl), .in_valid(sq_valid), .s(s), .side_in(side_in),
      .out_valid(root_valid), .root(root), .side_out(side_out)
   );

   assign mag_d[0] = side_out[MB-1:0];
   assign mag_d[1] = side_out[2*MB-1:MB];
   assign mag_d[2] = side_out[3*MB-1:2*MB];

   tna_div #(.MB(MB), .NF(NORMAL_FRAC_BITS), .CF(COORD_FRAC_BITS)) u_div (
      .clock(clock), .ctl(ctl), .in_valid(root_valid), .limit(limit_ff),
      .root(root), .mag(mag_d), .neg(side_out[3*MB+2:3*MB]),
      .out_valid(rsp_chan.valid), .area(rsp_chan.area), .nrm(nrm),
      .degen(rsp_chan.degenerate)
   );

   assign rsp_chan.normal_x = nrm[0];
   assign rsp_chan.normal_y = nrm[1];
   assign rsp_chan.normal_z = nrm[2];

   // degenerate items carry a zero normal
   `TNA_ASSERT_IMPL(a_degen_zero, clock, reset, rsp_chan.valid && rsp_chan.degenerate, rsp_chan.normal_x == '0 && rsp_chan.normal_y == '0 && rsp_chan.normal_z == '0)

   // normal_x stays within plus or minus one
   `TNA_ASSERT_IMPL(a_normal_range, clock, reset, rsp_chan.valid, rsp_chan.normal_x <= $signed(NB'(ONE)) && rsp_chan.normal_x >= -$signed(NB'(ONE)))

   // reset empties the pipeline
   `TNA_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_chan.valid)
endmodule

[verif/tna_tb_if.sv]
// the rtl interfaces are reused as they are; this file holds the check item types
package tna_tb_pkg;

   localparam int COORD_W  = 24;
   localparam int AREA_W   = 38;
   localparam int NORMAL_W = 16;
   localparam int NF       = 14;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
   } tri_item_type;

   typedef struct packed {
      logic [AREA_W-1:0]          area;
      logic signed [NORMAL_W-1:0] normal_x, normal_y, normal_z;
      logic                       degenerate;
   } face_item_type;

endpackage

[verif/triangle_normal_and_area_tb.sv]
module triangle_normal_and_area_tb;
   import tna_pkg::*;
   import tna_tb_pkg::*;

   localparam int LATENCY   = 74;
   localparam int N_RANDOM  = 650;
   localparam int CYCLE_MAX = 400000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_WIDTH-1:0] csr_wdata;

   tna_req_if #(.COORD_BITS(COORD_W)) req_chan ();
   tna_rsp_if #(.AREA_BITS(AREA_W), .NORMAL_BITS(NORMAL_W)) rsp_chan ();

   triangle_normal_and_area i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   face_item_type face_queue[$];
   logic [15:0] limit_shadow;
   int errors;
   int cycle_count;
   logic quiet_tx;
   logic quiet_rx;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_MAX) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // integer square root, rounded down
   function automatic logic [95:0] floor_root(logic [191:0] sq);
      logic [95:0] r;
      logic [95:0] cand;
      r = '0;
      for (int b = 95; b >= 0; b--) begin
         cand = r | (96'd1 << b);
         if ({96'd0, cand} * {96'd0, cand} <= sq) r = cand;
      end
      return r;
   endfunction

   // truncated v * 2^NF / root
   function automatic logic [NORMAL_W-1:0] unit_part(logic signed [63:0] v,
                                                     logic [95:0] root);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (v < 0) ? 128'(-v) : 128'(v);
      q = (mag << NF) / {32'd0, root};
      return (v < 0) ? NORMAL_W'(-q) : NORMAL_W'(q);
   endfunction

   // expected area, normal and degenerate flag for one triangle
   function automatic face_item_type face_of(tri_item_type t, logic [15:0] lim);
      face_item_type f;
      logic signed [63:0] e1x, e1y, e1z, e2x, e2y, e2z, vx, vy, vz;
      logic [191:0] sq;
      logic [95:0] root;
      logic [95:0] len;
      e1x = 64'(t.b_x) - 64'(t.a_x);
      e1y = 64'(t.b_y) - 64'(t.a_y);
      e1z = 64'(t.b_z) - 64'(t.a_z);
      e2x = 64'(t.c_x) - 64'(t.a_x);
      e2y = 64'(t.c_y) - 64'(t.a_y);
      e2z = 64'(t.c_z) - 64'(t.a_z);
      vx = e1y * e2z - e1z * e2y;
      vy = e1z * e2x - e1x * e2z;
      vz = e1x * e2y - e1y * e2x;
      sq = {64'd0, 128'(128'(vx) * 128'(vx))} + {64'd0, 128'(128'(vy) * 128'(vy))}
           + {64'd0, 128'(128'(vz) * 128'(vz))};
      root = floor_root(sq);
      len = root >> 12;
      f.area = (len >> 1) > {58'd0, {AREA_W{1'b1}}} ? {AREA_W{1'b1}} : AREA_W'(len >> 1);
      f.degenerate = (len <= {80'd0, lim});
      f.normal_x = f.degenerate ? '0 : unit_part(vx, root);
      f.normal_y = f.degenerate ? '0 : unit_part(vy, root);
      f.normal_z = f.degenerate ? '0 : unit_part(vz, root);
      return f;
   endfunction

   // result checking and sink stalls
   always @(posedge clock) begin
      face_item_type exp_f;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (face_queue.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
         end else begin
            exp_f = face_queue.pop_front();
            if (rsp_chan.area !== exp_f.area) begin
               $error("area exp %0d got %0d", exp_f.area, rsp_chan.area);
               errors++;
            end
            if (rsp_chan.normal_x !== exp_f.normal_x) begin
               $error("normal_x exp %0d got %0d", exp_f.normal_x, rsp_chan.normal_x);
               errors++;
            end
            if (rsp_chan.normal_y !== exp_f.normal_y) begin
               $error("normal_y exp %0d got %0d", exp_f.normal_y, rsp_chan.normal_y);
               errors++;
            end
            if (rsp_chan.normal_z !== exp_f.normal_z) begin
               $error("normal_z exp %0d got %0d", exp_f.normal_z, rsp_chan.normal_z);
               errors++;
            end
            if (rsp_chan.degenerate !== exp_f.degenerate) begin
               $error("degenerate exp %0d got %0d", exp_f.degenerate,
                      rsp_chan.degenerate);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 17);
   end

   task automatic drive_tri(tri_item_type t);
      req_chan.valid <= 1'b1;
      {req_chan.a_x, req_chan.a_y, req_chan.a_z, req_chan.b_x, req_chan.b_y,
       req_chan.b_z, req_chan.c_x, req_chan.c_y, req_chan.c_z} <= t;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // push one triangle, with a random gap in front and an optional typed result
   task automatic send_tri(tri_item_type t, bit typed, face_item_type typed_f);
      @(negedge clock);
      while (!quiet_tx && $urandom_range(99) < 17) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      face_queue.insert(face_queue.size(), typed ? typed_f : face_of(t, limit_shadow));
      drive_tri(t);
   endtask

   task automatic drain_all();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (face_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic write_limit(logic [15:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      limit_shadow = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic signed [COORD_W-1:0] rnd_coord(int mode);
      unique case (mode)
         0: return COORD_W'($urandom);
         1: return COORD_W'($signed(14'($urandom)));
         default: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      endcase
   endfunction

   // directed table: vertices, whether a typed result applies, that result
   typedef struct {
      tri_item_type  t;
      bit            typed;
      face_item_type f;
   } tri_row_type;

   tri_row_type rows[$];
   localparam logic signed [23:0] PMAX = 24'sh7fffff;
   localparam logic signed [23:0] PMIN = 24'sh800000;
   localparam logic signed [23:0] ONE  = 24'sd4096;

   // append one row to the directed table
   task automatic add_row(tri_item_type t, bit typed, face_item_type f);
      tri_row_type r;
      r.t = t;
      r.typed = typed;
      r.f = f;
      rows.insert(rows.size(), r);
   endtask

   initial begin
      tri_item_type t;
      int mode;
      errors = 0;
      cycle_count = 0;
      quiet_tx = 1'b0;
      quiet_rx = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      limit_shadow = '0;
      req_chan.valid = 1'b0;
      {req_chan.a_x, req_chan.a_y, req_chan.a_z, req_chan.b_x, req_chan.b_y,
       req_chan.b_z, req_chan.c_x, req_chan.c_y, req_chan.c_z} = '0;
      rsp_chan.ready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all-zero triangle after reset: degenerate, zero area
      add_row('0, 1, '{area: 0, normal_x: 0, normal_y: 0, normal_z: 0, degenerate: 1});
      // unit right triangle in xy: area one half, normal +z
      add_row('{0, 0, 0, ONE, 0, 0, 0, ONE, 0}, 1,
              '{area: 2048, normal_x: 0, normal_y: 0, normal_z: 16384, degenerate: 0});
      // reversed winding: normal -z
      add_row('{0, 0, 0, 0, ONE, 0, ONE, 0, 0}, 1,
              '{area: 2048, normal_x: 0, normal_y: 0, normal_z: -16384, degenerate: 0});
      // axis normals on x and y
      add_row('{0, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1,
              '{area: 2048, normal_x: 16384, normal_y: 0, normal_z: 0, degenerate: 0});
      add_row('{0, 0, 0, 0, 0, ONE, ONE, 0, 0}, 1,
              '{area: 2048, normal_x: 0, normal_y: 16384, normal_z: 0, degenerate: 0});
      // collinear points: zero cross product
      add_row('{0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE}, 1,
              '{area: 0, normal_x: 0, normal_y: 0, normal_z: 0, degenerate: 1});
      // tiny triangle, length one lsb
      add_row('{0, 0, 0, 64, 0, 0, 0, 64, 0}, 0, '0);
      // extreme corners, then two irregular triangles
      add_row('{PMIN, PMIN, PMIN, PMAX, PMIN, PMIN, PMIN, PMAX, PMIN}, 0, '0);
      add_row('{PMAX, PMAX, PMAX, PMIN, PMAX, PMAX, PMAX, PMIN, PMAX}, 0, '0);
      add_row('{PMIN, PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, PMIN, PMAX}, 0, '0);
      add_row('{PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX, PMAX, PMIN}, 0, '0);
      add_row('{PMIN, PMIN, PMAX, PMAX, PMAX, PMIN, PMIN, PMAX, PMAX}, 0, '0);
      add_row('{-1, -1, -1, 1, 0, 0, 0, 1, 0}, 0, '0);
      add_row('{ONE, -ONE, 3, -5*ONE, 7, ONE, 9, 2*ONE, -ONE}, 0, '0);
      foreach (rows[i]) send_tri(rows[i].t, rows[i].typed, rows[i].f);
      drain_all();

      // limit extremes, 4096 and a random value; the sender waits for every result before each write
      for (int phase = 0; phase < 4; phase++) begin
         unique case (phase)
            0: write_limit(16'hffff);
            1: write_limit(16'd4096);
            2: write_limit(16'($urandom));
            default: write_limit(16'd0);
         endcase
         quiet_tx = (phase == 1);
         quiet_rx = (phase == 1);
         for (int k = 0; k < N_RANDOM / 4; k++) begin
            mode = $urandom_range(9);
            t.a_x = rnd_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
            t.a_y = rnd_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
            t.a_z = rnd_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
            t.b_x = rnd_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
            t.b_y = rnd_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
            t.b_z = rnd_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
            t.c_x = rnd_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
            t.c_y = rnd_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
            t.c_z = rnd_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
            // small near-degenerate sliver now and then
            if (mode == 4) begin
               t.b_x = t.a_x + 24'($urandom_range(300));
               t.b_y = t.a_y;
               t.b_z = t.a_z;
               t.c_x = t.a_x;
               t.c_y = t.a_y + 24'($urandom_range(300));
               t.c_z = t.a_z;
            end
            send_tri(t, 0, '0);
         end
         drain_all();
      end

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/tna_pkg.sv
rtl/tna_req_if.sv
rtl/tna_rsp_if.sv
rtl/tna_cross.sv
rtl/tna_square.sv
rtl/tna_sqrt.sv
rtl/tna_div.sv
rtl/triangle_normal_and_area.sv
verif/tna_tb_if.sv
verif/triangle_normal_and_area_tb.sv
